@@ rtl/csvft_pkg.sv @@
// csvft_pkg: types and constants for the CSV field tokenizer.
// No dependencies; used by csv_field_tokenizer, its checker and the test bench.

package csvft_pkg;

    // Fixed characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Separator after reset (comma)
    localparam logic [7:0] SEP_RESET = 8'h2C;

    // Input function codes
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_EOS  = 1'b1;

    // Result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_LINE_START  = 3'd0,
        PH_FIELD_START = 3'd1,
        PH_PLAIN       = 3'd2,
        PH_QUOTED      = 3'd3,
        PH_QUOTE_SEEN  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        K_CHAR         = 2'd0,
        K_END_FIELD    = 2'd1,
        K_END_RECORD   = 2'd2,
        K_EMPTY_RECORD = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_val;
    } result_t;

endpackage

@@ rtl/csv_field_tokenizer.sv @@
// csv_field_tokenizer: streaming CSV tokenizer, quoted fields, CR/LF/CRLF line ends.
// Depends on csvft_pkg.
//
// Path: an accepted item is held in the input register, parsed once the
//   queue has room, and its results are written into the result queue.
// Throughput: one item per cycle while the queue has room; an item with two
//   results (a pending empty record plus its own result) pushes both into the
//   four-entry result queue. The queue takes an item only with two free slots.
// Reset: parser returns to line start, CR and empty-line flags clear, the
//   queue empties and the separator returns to comma.

module csv_field_tokenizer
    import csvft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // separator register write
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // input item channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] ch,
    // result item channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_char
);

    // ------------------------------------------------------------------
    // Separator register
    // ------------------------------------------------------------------
    logic [7:0] sep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= SEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            sep_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register: holds one item until the parser can take it
    // ------------------------------------------------------------------
    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic       hold_func_reg;
    logic [7:0] hold_ch_reg;
    logic       in_accept;
    logic       proc_fire;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Parse only when the queue has room for the worst case of two results
    assign proc_fire = hold_valid_reg && (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign in_stall  = hold_valid_reg && !proc_fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_func_reg <= func;
            hold_ch_reg   <= ch;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t phase_reg;
    phase_t phase_next;
    logic   cr_seen_reg;
    logic   cr_seen_next;
    logic   pend_reg;       // empty line ended, its record not yet sent
    logic   pend_next;

    logic    emit_empty;    // pending empty record goes out first
    logic    main_valid;    // this character's own result
    result_t main_res;

    always_comb
    begin
        phase_next   = phase_reg;
        cr_seen_next = cr_seen_reg;
        pend_next    = pend_reg;
        emit_empty   = 1'b0;
        main_valid   = 1'b0;
        main_res     = '{kind: K_CHAR, char_val: 8'h00};

        if (hold_func_reg == FUNC_EOS)
        begin
            // end of stream: close an open line, drop a pending empty line
            if (phase_reg != PH_LINE_START)
            begin
                main_valid    = 1'b1;
                main_res.kind = K_END_RECORD;
            end
            phase_next   = PH_LINE_START;
            cr_seen_next = 1'b0;
            pend_next    = 1'b0;
        end
        else if (!(cr_seen_reg && hold_ch_reg == CH_LF))
        begin
            cr_seen_next = 1'b0;
            emit_empty   = pend_reg;
            pend_next    = 1'b0;

            if (hold_ch_reg == CH_CR || hold_ch_reg == CH_LF)
            begin
                cr_seen_next = (hold_ch_reg == CH_CR);
                if (phase_reg == PH_LINE_START)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    main_valid    = 1'b1;
                    main_res.kind = K_END_RECORD;
                end
                phase_next = PH_LINE_START;
            end
            else
            begin
                case (phase_reg)
                    PH_PLAIN:
                    begin
                        main_valid = 1'b1;
                        if (hold_ch_reg == sep_reg)
                        begin
                            main_res.kind = K_END_FIELD;
                            phase_next    = PH_FIELD_START;
                        end
                        else
                        begin
                            main_res.char_val = hold_ch_reg;
                        end
                    end
                    PH_QUOTED:
                    begin
                        if (hold_ch_reg == CH_QUOTE)
                        begin
                            phase_next = PH_QUOTE_SEEN;
                        end
                        else
                        begin
                            main_valid        = 1'b1;
                            main_res.char_val = hold_ch_reg;
                        end
                    end
                    PH_QUOTE_SEEN:
                    begin
                        main_valid = 1'b1;
                        if (hold_ch_reg == CH_QUOTE)
                        begin
                            // doubled quote
                            main_res.char_val = CH_QUOTE;
                            phase_next        = PH_QUOTED;
                        end
                        else if (hold_ch_reg == sep_reg)
                        begin
                            main_res.kind = K_END_FIELD;
                            phase_next    = PH_FIELD_START;
                        end
                        else
                        begin
                            // text after the closing quote is copied as is
                            main_res.char_val = hold_ch_reg;
                            phase_next        = PH_PLAIN;
                        end
                    end
                    default:
                    begin
                        // line start or field start
                        if (hold_ch_reg == CH_QUOTE)
                        begin
                            phase_next = PH_QUOTED;
                        end
                        else if (hold_ch_reg == sep_reg)
                        begin
                            main_valid    = 1'b1;
                            main_res.kind = K_END_FIELD;
                            phase_next    = PH_FIELD_START;
                        end
                        else
                        begin
                            main_valid        = 1'b1;
                            main_res.char_val = hold_ch_reg;
                            phase_next        = PH_PLAIN;
                        end
                    end
                endcase
            end
        end
        else
        begin
            // LF right after CR is swallowed
            cr_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LINE_START;
            cr_seen_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else if (proc_fire)
        begin
            phase_reg   <= phase_next;
            cr_seen_reg <= cr_seen_next;
            pend_reg    <= pend_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two pushes and one pop per cycle
    // ------------------------------------------------------------------
    result_t          res0;
    result_t          res1;
    logic [1:0]       push_n;
    logic             pop;
    result_t          fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;

    always_comb
    begin
        res0 = main_res;
        res1 = main_res;
        if (emit_empty)
        begin
            res0 = '{kind: K_EMPTY_RECORD, char_val: 8'h00};
        end
        push_n = 2'd0;
        if (proc_fire)
        begin
            push_n = {1'b0, emit_empty} + {1'b0, main_valid};
        end
    end

    assign pop         = out_valid && !out_stall;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign cnt_next    = cnt_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign kind      = fifo_mem[rd_ptr_reg].kind;
    assign out_char  = fifo_mem[rd_ptr_reg].char_val;

endmodule

@@ rtl/csvft_checker.sv @@
// csvft_checker: port-level assertions for csv_field_tokenizer, plus bind.
// Depends on csvft_pkg.

module csvft_checker
    import csvft_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] out_char
);

    // kind of the last result item delivered
    logic [1:0] last_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_kind_reg <= K_EMPTY_RECORD;
        end
        else if (out_valid && !out_stall)
        begin
            last_kind_reg <= kind;
        end
    end

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kind) && $stable(out_char))
        else $error("stalled result item changed");

    a_mark_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != K_CHAR |-> out_char == 8'h00)
        else $error("field or record mark carries a character");

    // after an end of field the line is open, so an empty record cannot follow
    a_no_empty_after_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_kind_reg == K_END_FIELD |-> kind != K_EMPTY_RECORD)
        else $error("empty record directly after end of field");

endmodule

bind csv_field_tokenizer csvft_checker u_csvft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_char  (out_char)
);

@@ tb/csv_field_tokenizer_test.sv @@
// csv_field_tokenizer_test: self-checking bench for the CSV field tokenizer.
// Depends on csvft_pkg and csv_field_tokenizer; the token predictor lives in
// csv_token_book below, stimulus and handshakes are plain tasks and processes.
`timescale 1ns / 100ps

// Tracks the tokenizer state from accepted items and holds the tokens still owed.
class csv_token_book;
    csvft_pkg::phase_t  phase;
    bit                 cr_flag;       // last char was CR, an LF next is eaten
    bit                 blank_pending; // empty line ended, record not yet emitted
    logic [7:0]         separator;
    csvft_pkg::result_t expected_tokens[$];
    int unsigned        mismatches;

    function new();
        separator   = csvft_pkg::SEP_RESET;
        mismatches  = 0;
        clear_line();
    endfunction

    function void clear_line();
        phase         = csvft_pkg::PH_LINE_START;
        cr_flag       = 1'b0;
        blank_pending = 1'b0;
    endfunction

    function void owe(csvft_pkg::kind_t k, logic [7:0] c);
        csvft_pkg::result_t r;
        r.kind     = k;
        r.char_val = c;
        expected_tokens = {expected_tokens, r};
    endfunction

    // Advance the tokenizer by one accepted item.
    function void note_item(logic f, logic [7:0] c);
        if (f == csvft_pkg::FUNC_EOS)
        begin
            if (phase != csvft_pkg::PH_LINE_START)
                owe(csvft_pkg::K_END_RECORD, 8'h00);
            clear_line();
            return;
        end
        if (cr_flag)
        begin
            cr_flag = 1'b0;
            if (c == csvft_pkg::CH_LF)
                return;
        end
        if (blank_pending)
        begin
            owe(csvft_pkg::K_EMPTY_RECORD, 8'h00);
            blank_pending = 1'b0;
        end
        if (c == csvft_pkg::CH_CR || c == csvft_pkg::CH_LF)
        begin
            if (c == csvft_pkg::CH_CR)
                cr_flag = 1'b1;
            if (phase == csvft_pkg::PH_LINE_START)
                blank_pending = 1'b1;
            else
                owe(csvft_pkg::K_END_RECORD, 8'h00);
            phase = csvft_pkg::PH_LINE_START;
            return;
        end
        case (phase)
            csvft_pkg::PH_PLAIN:
            begin
                if (c == separator)
                begin
                    owe(csvft_pkg::K_END_FIELD, 8'h00);
                    phase = csvft_pkg::PH_FIELD_START;
                end
                else
                    owe(csvft_pkg::K_CHAR, c);
            end
            csvft_pkg::PH_QUOTED:
            begin
                if (c == csvft_pkg::CH_QUOTE)
                    phase = csvft_pkg::PH_QUOTE_SEEN;
                else
                    owe(csvft_pkg::K_CHAR, c);
            end
            csvft_pkg::PH_QUOTE_SEEN:
            begin
                if (c == csvft_pkg::CH_QUOTE)
                begin
                    owe(csvft_pkg::K_CHAR, csvft_pkg::CH_QUOTE);
                    phase = csvft_pkg::PH_QUOTED;
                end
                else if (c == separator)
                begin
                    owe(csvft_pkg::K_END_FIELD, 8'h00);
                    phase = csvft_pkg::PH_FIELD_START;
                end
                else
                begin
                    owe(csvft_pkg::K_CHAR, c);
                    phase = csvft_pkg::PH_PLAIN;
                end
            end
            default:
            begin
                // line start and field start: quote wins over an equal separator
                if (c == csvft_pkg::CH_QUOTE)
                    phase = csvft_pkg::PH_QUOTED;
                else if (c == separator)
                begin
                    owe(csvft_pkg::K_END_FIELD, 8'h00);
                    phase = csvft_pkg::PH_FIELD_START;
                end
                else
                begin
                    owe(csvft_pkg::K_CHAR, c);
                    phase = csvft_pkg::PH_PLAIN;
                end
            end
        endcase
    endfunction

    // Compare one accepted output token with the oldest one owed.
    function void check_token(logic [1:0] k, logic [7:0] c);
        csvft_pkg::result_t r;
        if (expected_tokens.size() == 0)
        begin
            $display("%0t: token with none owed: expected none, actual kind %0d char %02h",
                     $time, k, c);
            mismatches++;
            return;
        end
        r = expected_tokens.pop_front();
        if (k !== r.kind)
        begin
            $display("%0t: kind mismatch: expected %0d, actual %0d", $time, r.kind, k);
            mismatches++;
        end
        if (c !== r.char_val)
        begin
            $display("%0t: out_char mismatch: expected %02h, actual %02h",
                     $time, r.char_val, c);
            mismatches++;
        end
    endfunction
endclass

module csv_field_tokenizer_test;
    import csvft_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 120;  // receiver hold-off that backs up the queue
    localparam int DRAIN_PAD   = 8;    // covers the input register, parse path and queue

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       func        = FUNC_CHAR;
    logic [7:0] ch          = 8'h00;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_char;

    csv_token_book book = new();

    // idle_on gates random gaps on both sides; hold_requests asks the
    // receiver for one long hold-off per increment.
    bit          idle_on       = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned items_sent    = 0;
    int unsigned cycle_count   = 0;

    // receiver-private counters
    int unsigned holds_done = 0;
    int          hold_left  = 0;
    int          burst_left = 0;

    csv_field_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_char    (out_char)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check what was taken at this edge, then pick next stall.
    // The long hold-off is counted here so the sender keeps pushing meanwhile.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_token(kind, out_char);
        if (holds_done != hold_requests)
        begin
            holds_done++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            burst_left = $urandom_range(1, 14) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Offer one item, possibly after an idle burst, and wait for it to be taken.
    task automatic send_item(input logic f, input logic [7:0] c);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        ch       <= c;
        do @(posedge clk); while (in_stall);
        book.note_item(f, c);
        items_sent++;
    endtask

    // Stop offering and let every owed token drain; the DRAIN_PAD wait after that
    // covers items with no token that may still be in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (book.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        book.separator = v;
    endtask

    // Field byte that is neither separator, quote nor line end.
    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 1))
                c = 8'($urandom_range(8'h61, 8'h7A));
            else
                c = 8'($urandom_range(0, 255));
        end while (c == book.separator || c == CH_QUOTE || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    task automatic send_line_end();
        case ($urandom_range(0, 2))
            0: send_item(FUNC_CHAR, CH_CR);
            1: send_item(FUNC_CHAR, CH_LF);
            default:
            begin
                send_item(FUNC_CHAR, CH_CR);
                send_item(FUNC_CHAR, CH_LF);
            end
        endcase
    endtask

    task automatic send_field();
        int style;
        int len;
        style = $urandom_range(0, 9);
        if (style <= 4)
        begin
            // plain text, possibly empty
            len = $urandom_range(0, 5);
            repeat (len) send_item(FUNC_CHAR, pick_text_char());
        end
        else if (style <= 7)
        begin
            // quoted, with embedded separators and doubled quotes
            send_item(FUNC_CHAR, CH_QUOTE);
            len = $urandom_range(0, 5);
            repeat (len)
            begin
                case ($urandom_range(0, 5))
                    0: send_item(FUNC_CHAR, book.separator);
                    1:
                    begin
                        send_item(FUNC_CHAR, CH_QUOTE);
                        send_item(FUNC_CHAR, CH_QUOTE);
                    end
                    default: send_item(FUNC_CHAR, pick_text_char());
                endcase
            end
            send_item(FUNC_CHAR, CH_QUOTE);
            // stray text after the closing quote
            if ($urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(1, 3);
                repeat (len) send_item(FUNC_CHAR, pick_text_char());
            end
        end
        else if (style == 8)
        begin
            // raw noise, line ends and quotes included
            len = $urandom_range(1, 4);
            repeat (len) send_item(FUNC_CHAR, 8'($urandom_range(0, 255)));
        end
        else
        begin
            // quote left open until the line ends
            send_item(FUNC_CHAR, CH_QUOTE);
            len = $urandom_range(0, 3);
            repeat (len) send_item(FUNC_CHAR, pick_text_char());
        end
    endtask

    task automatic send_record();
        int nfields;
        nfields = $urandom_range(1, 4);
        for (int i = 0; i < nfields; i++)
        begin
            if (i != 0)
                send_item(FUNC_CHAR, book.separator);
            send_field();
        end
        if ($urandom_range(0, 5) == 0)
            send_item(FUNC_CHAR, book.separator);  // empty last field
        if ($urandom_range(0, 7) == 0)
        begin
            // record cut short by end of stream
            send_item(FUNC_EOS, 8'($urandom_range(0, 255)));
            return;
        end
        send_line_end();
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) send_line_end();  // blank lines
        if ($urandom_range(0, 9) == 0)
            send_item(FUNC_EOS, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_records(input int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target)
            send_record();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass with the reset separator (comma).
        send_item(FUNC_CHAR, "a");
        send_item(FUNC_CHAR, ",");
        send_item(FUNC_CHAR, CH_QUOTE);     // quoted field holding a comma
        send_item(FUNC_CHAR, ",");
        send_item(FUNC_CHAR, CH_QUOTE);
        send_item(FUNC_CHAR, CH_QUOTE);     // doubled quote -> one quote
        send_item(FUNC_CHAR, CH_QUOTE);
        send_item(FUNC_CHAR, "x");          // text after closing quote
        send_item(FUNC_CHAR, ",");
        send_item(FUNC_CHAR, ",");          // empty field
        send_item(FUNC_CHAR, CH_CR);
        send_item(FUNC_CHAR, CH_LF);        // CRLF pair
        send_item(FUNC_CHAR, CH_CR);        // empty line
        send_item(FUNC_CHAR, CH_CR);        // CR CR: second empty line
        send_item(FUNC_CHAR, 8'h00);        // empty record plus char
        send_item(FUNC_CHAR, 8'hFF);
        send_item(FUNC_CHAR, CH_QUOTE);     // quote inside plain text
        send_item(FUNC_CHAR, CH_LF);
        send_item(FUNC_CHAR, CH_QUOTE);
        send_item(FUNC_CHAR, "q");
        send_item(FUNC_CHAR, CH_LF);        // line end inside quotes
        send_item(FUNC_CHAR, CH_LF);        // empty line, then dropped at EOS
        send_item(FUNC_EOS, 8'hFF);
        send_item(FUNC_CHAR, CH_QUOTE);     // unclosed quote at EOS
        send_item(FUNC_EOS, 8'h00);
        send_item(FUNC_EOS, 8'h5A);         // EOS on an idle line
        settle();

        idle_on <= 1'b1;
        write_separator(8'h00);
        run_records(110);
        settle();

        // Long receiver hold-off while items keep coming.
        write_separator(8'hFF);
        hold_requests <= hold_requests + 1;
        run_records(110);
        settle();

        // Separator colliding with quote, then with each line end.
        write_separator(CH_QUOTE);
        run_records(40);
        settle();
        write_separator(CH_CR);
        run_records(30);
        settle();
        write_separator(CH_LF);
        run_records(30);
        settle();
        write_separator(8'($urandom_range(0, 255)));
        run_records(110);
        settle();

        // Final stretch back at comma, no gaps on either side.
        idle_on <= 1'b0;
        write_separator(SEP_RESET);
        run_records(130);
        send_item(FUNC_EOS, 8'h00);
        settle();

        if (book.mismatches == 0 && book.expected_tokens.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ csv_field_tokenizer.f @@
rtl/csvft_pkg.sv
rtl/csv_field_tokenizer.sv
rtl/csvft_checker.sv
tb/csv_field_tokenizer_test.sv
